/* rtl/charger_plug_detect_assert.svh */
// assertion macros for the charger plug detector
// expects clk and rst_n in the including module's scope
`ifndef CHARGER_PLUG_DETECT_ASSERT_SVH
`define CHARGER_PLUG_DETECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CPD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`define CPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define CPD_ASSERT_IMPLIES(label, ante, cons)

`define CPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/cpd_pkg.sv */
// shared types and constants for the charger plug detector
// no dependencies
package cpd_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int ValW     = 16;
    localparam int DelayW   = 7;
    localparam int CntW     = 8;
    localparam int InDataW  = 88;
    localparam int OutDataW = 8;

    localparam logic signed [ValW-1:0] PackCurrentLimit = 16'sd1000;
    localparam logic [ValW-1:0]        UnplugVoltMargin = 16'd250;

    localparam logic [ValW-1:0]   SmallChgReset   = 16'd200;
    localparam logic [ValW-1:0]   OutChgReset     = 16'd50;
    localparam logic [ValW-1:0]   UnloadDisReset  = 16'd200;
    localparam logic [ValW-1:0]   VoltOffsetReset = 16'd1000;
    localparam logic [ValW-1:0]   HighVoltReset   = 16'd60000;
    localparam logic [DelayW-1:0] PluginReset     = 7'd50;
    localparam logic [DelayW-1:0] PlugoutReset    = 7'd50;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SMALL_CHARGE_CURRENT     = 3'd0,
        REG_OUT_CHARGE_CURRENT       = 3'd1,
        REG_UNLOAD_DISCHARGE_CURRENT = 3'd2,
        REG_VOLTAGE_OFFSET           = 3'd3,
        REG_VALID_HIGH_VOLTAGE       = 3'd4,
        REG_PLUGIN_DELAY             = 3'd5,
        REG_PLUGOUT_DELAY            = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                   mt_plugin;
        logic                   ecu_plugin;
        logic [ValW-1:0]        stack_voltage;
        logic [ValW-1:0]        pack_voltage;
        logic signed [ValW-1:0] pack_current;
        logic [ValW-1:0]        discharge_current_avg;
        logic [ValW-1:0]        charge_current_avg;
        logic                   power_off;
    } tick_t;

    typedef struct packed {
        logic sleep_pause;
        logic wake_active;
        logic clear_faults;
        logic charger_error;
        logic plugged_in;
    } result_t;

endpackage

/* rtl/charger_plug_detect.sv */
// charger plug-in / plug-out detector, one tick per input beat
// depends on cpd_pkg and charger_plug_detect_assert.svh
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: one 10 ms tick
//  m_*      | out | m_tvalid/m_tready  | m_tdata: one result per tick
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// input beat to result passes the input register, then the whole
// tick update in one pass into the result register and the counters
// one beat per cycle sustained; s_tready drops only when both registers
// are full and m_tready is low
// rst_n clears control state, counters and registers to power-up values
// cfg_ready is always high
module charger_plug_detect (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // power_off, charge_current_avg, discharge_current_avg, pack_current,
    // pack_voltage, stack_voltage, ecu_plugin, mt_plugin, zero pad
    input  logic [cpd_pkg::InDataW-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // plugged_in, charger_error, clear_faults, wake_active, sleep_pause, zero pad
    output logic [cpd_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [cpd_pkg::CfgDataW-1:0]  cfg_data
);
    import cpd_pkg::*;

    `include "charger_plug_detect_assert.svh"

    localparam int TickW = $bits(tick_t);
    localparam int ResW  = $bits(result_t);

    // configuration
    logic [ValW-1:0]   small_chg_reg, out_chg_reg, unload_dis_reg;
    logic [ValW-1:0]   volt_offset_reg, high_volt_reg;
    logic [DelayW-1:0] plugin_delay_reg, plugout_delay_reg;

    // pipeline
    logic    in_valid_reg, out_valid_reg;
    tick_t   in_reg;
    result_t out_reg, res_next;
    logic    advance;

    // tick state
    logic            plugged_flag_reg, plugged_flag_next;
    logic            cleared_mark_reg, cleared_mark_next;
    logic [CntW-1:0] current_in_count_reg, current_in_count_next;
    logic [CntW-1:0] voltage_in_count_reg, voltage_in_count_next;
    logic [CntW-1:0] out_count_reg, out_count_next;
    logic [ValW-1:0] low_current_out_count_reg, low_current_out_count_next;
    logic [ValW-1:0] bad_charger_count_reg, bad_charger_count_next;

    // detector terms
    logic            cur_det, volt_det, high_volt, out_det, low_det;
    logic [CntW-1:0] plugin_x2, plugout_x2;
    logic [ValW:0]   stack_plus_offset, stack_plus_margin;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutDataW-ResW){1'b0}}, out_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_chg_reg     <= SmallChgReset;
            out_chg_reg       <= OutChgReset;
            unload_dis_reg    <= UnloadDisReset;
            volt_offset_reg   <= VoltOffsetReset;
            high_volt_reg     <= HighVoltReset;
            plugin_delay_reg  <= PluginReset;
            plugout_delay_reg <= PlugoutReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SMALL_CHARGE_CURRENT:     small_chg_reg     <= cfg_data;
                REG_OUT_CHARGE_CURRENT:       out_chg_reg       <= cfg_data;
                REG_UNLOAD_DISCHARGE_CURRENT: unload_dis_reg    <= cfg_data;
                REG_VOLTAGE_OFFSET:           volt_offset_reg   <= cfg_data;
                REG_VALID_HIGH_VOLTAGE:       high_volt_reg     <= cfg_data;
                REG_PLUGIN_DELAY:             plugin_delay_reg  <= cfg_data[DelayW-1:0];
                REG_PLUGOUT_DELAY:            plugout_delay_reg <= cfg_data[DelayW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        plugin_x2         = {plugin_delay_reg, 1'b0};
        plugout_x2        = {plugout_delay_reg, 1'b0};
        stack_plus_offset = {1'b0, in_reg.stack_voltage} + {1'b0, volt_offset_reg};
        stack_plus_margin = {1'b0, in_reg.stack_voltage} + {1'b0, UnplugVoltMargin};

        cur_det   = (in_reg.charge_current_avg > small_chg_reg)
                    || (in_reg.pack_current > PackCurrentLimit)
                    || in_reg.ecu_plugin;
        volt_det  = {1'b0, in_reg.pack_voltage} > stack_plus_offset;
        high_volt = in_reg.pack_voltage > high_volt_reg;
        out_det   = (in_reg.discharge_current_avg > unload_dis_reg)
                    || (in_reg.pack_voltage < {1'b0, in_reg.stack_voltage[ValW-1:1]})
                    || (!in_reg.ecu_plugin && (in_reg.charge_current_avg < small_chg_reg));
        low_det   = (in_reg.charge_current_avg < out_chg_reg)
                    && ({1'b0, in_reg.pack_voltage} < stack_plus_margin);

        plugged_flag_next          = plugged_flag_reg;
        cleared_mark_next          = cleared_mark_reg;
        current_in_count_next      = current_in_count_reg;
        voltage_in_count_next      = voltage_in_count_reg;
        out_count_next             = out_count_reg;
        low_current_out_count_next = low_current_out_count_reg;
        bad_charger_count_next     = bad_charger_count_reg;
        res_next                   = '0;

        if (!in_reg.power_off)
        begin
            if (!plugged_flag_reg)
            begin
                out_count_next = '0;
                if (cur_det)
                begin
                    current_in_count_next = (&current_in_count_reg) ? current_in_count_reg
                                            : current_in_count_reg + 1'b1;
                    if (current_in_count_next > plugin_x2)
                    begin
                        plugged_flag_next     = 1'b1;
                        res_next.clear_faults = 1'b1;
                    end
                    res_next.sleep_pause = 1'b1;
                end
                else
                begin
                    current_in_count_next = '0;
                end

                if (volt_det)
                begin
                    if (high_volt)
                    begin
                        bad_charger_count_next = (&bad_charger_count_reg)
                                                 ? bad_charger_count_reg
                                                 : bad_charger_count_reg + 1'b1;
                        // compare uses the count from before this tick
                        if (bad_charger_count_reg > {{(ValW-CntW){1'b0}}, plugin_x2})
                        begin
                            res_next.charger_error = 1'b1;
                            plugged_flag_next      = 1'b1;
                        end
                        // voltage count restarts from zero and counts this tick
                        voltage_in_count_next = {{(CntW-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        bad_charger_count_next = '0;
                        voltage_in_count_next  = (&voltage_in_count_reg)
                                                 ? voltage_in_count_reg
                                                 : voltage_in_count_reg + 1'b1;
                    end
                    if (voltage_in_count_next > {1'b0, plugin_delay_reg})
                    begin
                        plugged_flag_next     = 1'b1;
                        res_next.clear_faults = 1'b1;
                        res_next.wake_active  = 1'b1;
                    end
                    res_next.sleep_pause = 1'b1;
                end
                else
                begin
                    voltage_in_count_next  = '0;
                    bad_charger_count_next = '0;
                end
            end
            else
            begin
                current_in_count_next = '0;
                if (out_det)
                begin
                    out_count_next = (&out_count_reg) ? out_count_reg : out_count_reg + 1'b1;
                    if (out_count_next > plugout_x2)
                        plugged_flag_next = 1'b0;
                end
                else
                begin
                    out_count_next = '0;
                end
                if (low_det)
                begin
                    low_current_out_count_next = (&low_current_out_count_reg)
                                                 ? low_current_out_count_reg
                                                 : low_current_out_count_reg + 1'b1;
                    if (low_current_out_count_next
                        > {{(ValW-DelayW){1'b0}}, plugout_delay_reg})
                        plugged_flag_next = 1'b0;
                end
                else
                begin
                    low_current_out_count_next = '0;
                end
            end

            // faults are cleared once per registered charger, on the mt line
            if (!plugged_flag_next)
            begin
                cleared_mark_next = 1'b0;
            end
            else if (!cleared_mark_reg && in_reg.mt_plugin)
            begin
                cleared_mark_next     = 1'b1;
                res_next.clear_faults = 1'b1;
            end
        end

        res_next.plugged_in = plugged_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            plugged_flag_reg          <= 1'b0;
            cleared_mark_reg          <= 1'b0;
            current_in_count_reg      <= '0;
            voltage_in_count_reg      <= '0;
            out_count_reg             <= '0;
            low_current_out_count_reg <= '0;
            bad_charger_count_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                plugged_flag_reg          <= plugged_flag_next;
                cleared_mark_reg          <= cleared_mark_next;
                current_in_count_reg      <= current_in_count_next;
                voltage_in_count_reg      <= voltage_in_count_next;
                out_count_reg             <= out_count_next;
                low_current_out_count_reg <= low_current_out_count_next;
                bad_charger_count_reg     <= bad_charger_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= tick_t'(s_tdata[TickW-1:0]);
        if (advance)
            out_reg <= res_next;
    end

    `CPD_ASSERT_IMPLIES(a_wake_clears, out_valid_reg && out_reg.wake_active, out_reg.clear_faults)
    `CPD_ASSERT_IMPLIES(a_err_plugged, out_valid_reg && out_reg.charger_error, out_reg.plugged_in)
    `CPD_ASSERT_IMPLIES(a_mark_needs_flag, cleared_mark_reg, plugged_flag_reg)
    `CPD_ASSERT_NEXT(a_flag_only_on_beat, !advance, $stable(plugged_flag_reg))

endmodule

/* tb/sv/tb_charger_plug_detect.sv */
// self-checking testbench for charger_plug_detect: directed table, then random tick runs
// over several register settings, each result checked against a typed row or a tick-level predictor
// depends on cpd_pkg and the charger_plug_detect rtl
`timescale 1ns / 100ps

module tb_charger_plug_detect;
    import cpd_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_PHASE    = 3;
    localparam int HOLD_PHASE    = 6;
    localparam int RECONF_ROW    = 9;
    localparam int SHORT_ITEMS   = 160;
    localparam int LONG_ITEMS    = 300;
    localparam int MAX_REPORTS   = 40;

    localparam logic [CfgIdxW-1:0] CFG_IDX_UNMAPPED = 3'd7;

    // result_t from msb: sleep_pause, wake_active, clear_faults, charger_error, plugged_in
    localparam result_t RES_QUIET = 5'b00000;
    localparam result_t RES_PAUSE = 5'b10000;

    typedef enum logic [3:0] {
        SC_CHG_IN, SC_CUR_IN, SC_ECU_IN, SC_VOLT_IN, SC_BAD_VOLT,
        SC_DIS_OUT, SC_LOW_OUT, SC_HALF_OUT,
        SC_QUIET, SC_NOISE
    } scen_t;

    typedef struct {
        bit      typed;
        result_t want;
    } tick_note_t;

    typedef struct {
        tick_t   t;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [ValW-1:0]   thr_small_chg   = SmallChgReset;
    logic [ValW-1:0]   thr_out_chg     = OutChgReset;
    logic [ValW-1:0]   thr_unload_dis  = UnloadDisReset;
    logic [ValW-1:0]   thr_volt_offset = VoltOffsetReset;
    logic [ValW-1:0]   thr_high_volt   = HighVoltReset;
    logic [DelayW-1:0] dly_plugin      = PluginReset;
    logic [DelayW-1:0] dly_plugout     = PlugoutReset;

    // predictor copy of the detector state
    logic          st_plugged     = 1'b0;
    logic          st_cleared     = 1'b0;
    logic [7:0]    st_cur_in_cnt  = '0;
    logic [7:0]    st_volt_in_cnt = '0;
    logic [7:0]    st_out_cnt     = '0;
    logic [15:0]   st_low_out_cnt = '0;
    logic [15:0]   st_bad_cnt     = '0;

    result_t    status_due_q [$];
    tick_note_t note_q [$];
    dir_row_t   dir_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors = 0;
    int n_ticks = 0;
    int n_results = 0;
    int n_cfg = 0;
    int n_settings = 0;
    int n_plugins = 0;
    int n_removals = 0;
    int n_err_pulses = 0;
    int n_clr_pulses = 0;
    int n_wake_pulses = 0;
    logic last_plugged = 1'b0;

    result_t got_res;
    result_t want_res;
    tick_t   seen_tick;
    tick_note_t seen_note;

    charger_plug_detect DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic compare_bit(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    function automatic logic [7:0] sat_inc8(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // advances the predictor state by one tick and returns the status it reports
    function automatic result_t next_plug_status(tick_t t);
        result_t r;
        int chg;
        int dis;
        int cur;
        int pack;
        int stack;
        r = RES_QUIET;
        chg = t.charge_current_avg;
        dis = t.discharge_current_avg;
        cur = $signed(t.pack_current);
        pack = t.pack_voltage;
        stack = t.stack_voltage;
        if (!t.power_off)
        begin
            if (!st_plugged)
            begin
                st_out_cnt = '0;
                if (chg > thr_small_chg || cur > PackCurrentLimit || t.ecu_plugin)
                begin
                    st_cur_in_cnt = sat_inc8(st_cur_in_cnt);
                    if (st_cur_in_cnt > 2 * dly_plugin)
                    begin
                        st_plugged = 1'b1;
                        r.clear_faults = 1'b1;
                    end
                    r.sleep_pause = 1'b1;
                end
                else
                    st_cur_in_cnt = '0;
                // sums are 32 bit here, so no wrap
                if (pack > stack + thr_volt_offset)
                begin
                    if (pack > thr_high_volt)
                    begin
                        // faulty charger compares the count from before this tick
                        if (st_bad_cnt > 2 * dly_plugin)
                        begin
                            r.charger_error = 1'b1;
                            st_plugged = 1'b1;
                        end
                        st_volt_in_cnt = '0;
                        st_bad_cnt = sat_inc16(st_bad_cnt);
                    end
                    else
                        st_bad_cnt = '0;
                    st_volt_in_cnt = sat_inc8(st_volt_in_cnt);
                    if (st_volt_in_cnt > dly_plugin)
                    begin
                        st_plugged = 1'b1;
                        r.clear_faults = 1'b1;
                        r.wake_active = 1'b1;
                    end
                    r.sleep_pause = 1'b1;
                end
                else
                begin
                    st_volt_in_cnt = '0;
                    st_bad_cnt = '0;
                end
            end
            else
            begin
                st_cur_in_cnt = '0;
                if (dis > thr_unload_dis || pack < stack / 2 ||
                    (!t.ecu_plugin && chg < thr_small_chg))
                begin
                    st_out_cnt = sat_inc8(st_out_cnt);
                    if (st_out_cnt > 2 * dly_plugout)
                        st_plugged = 1'b0;
                end
                else
                    st_out_cnt = '0;
                if (chg < thr_out_chg && pack < stack + UnplugVoltMargin)
                begin
                    st_low_out_cnt = sat_inc16(st_low_out_cnt);
                    if (st_low_out_cnt > dly_plugout)
                        st_plugged = 1'b0;
                end
                else
                    st_low_out_cnt = '0;
            end
            if (!st_plugged)
                st_cleared = 1'b0;
            else if (!st_cleared && t.mt_plugin)
            begin
                st_cleared = 1'b1;
                r.clear_faults = 1'b1;
            end
        end
        r.plugged_in = st_plugged;
        return r;
    endfunction

    // all beats are observed here: results first, then ticks, then register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_res = m_tdata[$bits(result_t)-1:0];
                if (status_due_q.size() == 0)
                    report_mismatch("result beat with no tick pending", m_tdata, 0);
                else
                begin
                    want_res = status_due_q.pop_front();
                    compare_bit("plugged_in", got_res.plugged_in, want_res.plugged_in);
                    compare_bit("charger_error", got_res.charger_error, want_res.charger_error);
                    compare_bit("clear_faults", got_res.clear_faults, want_res.clear_faults);
                    compare_bit("wake_active", got_res.wake_active, want_res.wake_active);
                    compare_bit("sleep_pause", got_res.sleep_pause, want_res.sleep_pause);
                end
                if (got_res.plugged_in && !last_plugged)
                    n_plugins++;
                if (!got_res.plugged_in && last_plugged)
                    n_removals++;
                last_plugged = got_res.plugged_in;
                n_err_pulses += got_res.charger_error;
                n_clr_pulses += got_res.clear_faults;
                n_wake_pulses += got_res.wake_active;
                n_results++;
            end
            if (s_tvalid && s_tready)
            begin
                seen_tick = s_tdata[$bits(tick_t)-1:0];
                seen_note = note_q.pop_front();
                want_res = next_plug_status(seen_tick);
                if (seen_note.typed)
                    want_res = seen_note.want;
                status_due_q.push_back(want_res);
                n_ticks++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SMALL_CHARGE_CURRENT:     thr_small_chg = cfg_data;
                    REG_OUT_CHARGE_CURRENT:       thr_out_chg = cfg_data;
                    REG_UNLOAD_DISCHARGE_CURRENT: thr_unload_dis = cfg_data;
                    REG_VOLTAGE_OFFSET:           thr_volt_offset = cfg_data;
                    REG_VALID_HIGH_VOLTAGE:       thr_high_volt = cfg_data;
                    REG_PLUGIN_DELAY:             dly_plugin = cfg_data[DelayW-1:0];
                    REG_PLUGOUT_DELAY:            dly_plugout = cfg_data[DelayW-1:0];
                    default: ;
                endcase
                n_cfg++;
            end
        end
    end

    // counts cycles in which no channel moves a beat
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                           (cfg_valid && cfg_ready)))
                stall++;
            else
                stall = 0;
        end
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, status_due_q.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_tick(input tick_t t, input bit typed, input result_t want);
        tick_note_t note;
        note.typed = typed;
        note.want = want;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        note_q.push_back(note);
        s_tvalid <= 1'b1;
        s_tdata <= {{(InDataW - $bits(tick_t)){1'b0}}, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic sender_stop();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (status_due_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic cfg_stop();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input bit po, input int chg, input int dis, input int cur,
                           input int pack, input int stack, input bit ecu, input bit mt,
                           input bit typed, input result_t want);
        dir_row_t row;
        row.t.power_off = po;
        row.t.charge_current_avg = 16'(chg);
        row.t.discharge_current_avg = 16'(dis);
        row.t.pack_current = 16'(cur);
        row.t.pack_voltage = 16'(pack);
        row.t.stack_voltage = 16'(stack);
        row.t.ecu_plugin = ecu;
        row.t.mt_plugin = mt;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic int above(int thr);
        int room;
        if (thr >= 65535)
            return 65535;
        room = 65534 - thr;
        return thr + 1 + $urandom_range(0, (room < 400) ? room : 400);
    endfunction

    function automatic int below(int thr);
        int lo;
        if (thr <= 0)
            return 0;
        lo = (thr > 400) ? thr - 400 : 0;
        return $urandom_range(lo, thr - 1);
    endfunction

    function automatic scen_t pick_scenario();
        if ($urandom_range(0, 99) < 12)
            return SC_NOISE;
        if ($urandom_range(0, 99) < 70)
            return st_plugged ? scen_t'($urandom_range(SC_DIS_OUT, SC_HALF_OUT))
                              : scen_t'($urandom_range(SC_CHG_IN, SC_BAD_VOLT));
        return scen_t'($urandom_range(SC_CHG_IN, SC_QUIET));
    endfunction

    // random content that keeps the chosen detector condition true
    function automatic tick_t make_tick(scen_t sc);
        tick_t t;
        int stk;
        int lo;
        int hi;
        t.power_off = 1'b0;
        t.charge_current_avg = 16'($urandom_range(0, 65535));
        t.discharge_current_avg = 16'($urandom_range(0, 65535));
        t.pack_current = 16'($urandom_range(0, 65535));
        t.pack_voltage = 16'($urandom_range(0, 65535));
        t.stack_voltage = 16'($urandom_range(0, 65535));
        t.ecu_plugin = 1'($urandom_range(0, 1));
        t.mt_plugin = 1'($urandom_range(0, 1));
        case (sc)
            SC_CHG_IN:  t.charge_current_avg = 16'(above(thr_small_chg));
            SC_CUR_IN:  t.pack_current = 16'($urandom_range(1001, 32767));
            SC_ECU_IN:  t.ecu_plugin = 1'b1;
            SC_VOLT_IN, SC_BAD_VOLT:
            begin
                t.charge_current_avg = 16'($urandom_range(0, thr_small_chg));
                t.pack_current = 16'(int'($urandom_range(0, 33768)) - 32768);
                t.ecu_plugin = 1'b0;
                stk = $urandom_range(0, (sc == SC_BAD_VOLT) ? 20000 : 30000);
                lo = stk + thr_volt_offset + 1;
                hi = lo + 300;
                if (sc == SC_BAD_VOLT && lo <= thr_high_volt)
                begin
                    lo = thr_high_volt + 1;
                    hi = lo + 300;
                end
                else if (sc == SC_VOLT_IN && lo <= thr_high_volt && hi > thr_high_volt)
                    hi = thr_high_volt;
                if (hi > 65535)
                    hi = 65535;
                t.stack_voltage = 16'(stk);
                t.pack_voltage = (lo > 65535) ? 16'hFFFF : 16'($urandom_range(lo, hi));
            end
            SC_DIS_OUT: t.discharge_current_avg = 16'(above(thr_unload_dis));
            SC_LOW_OUT:
            begin
                t.charge_current_avg = 16'(below(thr_out_chg));
                stk = $urandom_range(0, 60000);
                t.stack_voltage = 16'(stk);
                t.pack_voltage = 16'($urandom_range(0, stk + 249));
            end
            SC_HALF_OUT:
            begin
                stk = $urandom_range(2, 65535);
                t.stack_voltage = 16'(stk);
                t.pack_voltage = 16'($urandom_range(0, stk / 2 - 1));
            end
            SC_QUIET:
            begin
                // charge, discharge, pack current and voltage offset thresholds hit exactly, none crossed
                t.charge_current_avg = thr_small_chg;
                t.discharge_current_avg = thr_unload_dis;
                t.pack_current = PackCurrentLimit;
                t.ecu_plugin = 1'b0;
                stk = $urandom_range(0, 65535 - thr_volt_offset);
                t.stack_voltage = 16'(stk);
                t.pack_voltage = 16'(stk + thr_volt_offset);
            end
            default: t.power_off = 1'($urandom_range(0, 1));
        endcase
        if (sc != SC_NOISE && $urandom_range(0, 99) < 4)
            t.power_off = 1'b1;
        return t;
    endfunction

    task automatic run_random(input int n_items, input bit hold_mid);
        int sent;
        int k;
        int seq_len;
        int dmax;
        scen_t sc;
        sent = 0;
        while (sent < n_items)
        begin
            sc = pick_scenario();
            dmax = (dly_plugin > dly_plugout) ? dly_plugin : dly_plugout;
            seq_len = $urandom_range(1, 2 * dmax + 8);
            for (k = 0; k < seq_len && sent < n_items; k++)
            begin
                if (hold_mid && sent == n_items / 2)
                begin
                    // let the pipeline run dry before going on
                    sender_stop();
                    wait_drained();
                end
                send_tick(make_tick(sc), 1'b0, RES_QUIET);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [CfgDataW-1:0] phase_cfg [7];
        cfg_reg_t reg_id;
        logic [CfgDataW-1:0] wdata;
        int i;
        int ph;

        // power_off, chg, dis, cur, pack, stack, ecu, mt, typed, want
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, RES_QUIET);
        add_row(1, 65535, 65535, 32767, 65535, 65535, 1, 1, 1, RES_QUIET);
        add_row(0, 65535, 0, 0, 0, 0, 0, 0, 1, RES_PAUSE);
        add_row(0, 0, 0, 32767, 0, 0, 0, 0, 1, RES_PAUSE);
        add_row(0, 0, 0, -32768, 0, 0, 0, 0, 1, RES_QUIET);
        add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, RES_PAUSE);
        add_row(0, 0, 0, 0, 65535, 0, 0, 0, 1, RES_PAUSE);
        add_row(0, 0, 0, 0, 65535, 65535, 0, 0, 1, RES_QUIET);
        add_row(0, 0, 0, 1000, 1000, 0, 0, 1, 1, RES_QUIET);
        // from here both delays are 1: plug in on charge current, clear once on mt
        for (i = 0; i < 3; i++)
            add_row(0, 300, 0, 0, 30000, 30000, 0, 0, 0, RES_QUIET);
        add_row(0, 300, 0, 0, 30000, 30000, 0, 1, 0, RES_QUIET);
        for (i = 0; i < 2; i++)
            add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, RES_QUIET);
        // voltage path wakes, discharge removes, then a faulty charger
        for (i = 0; i < 2; i++)
            add_row(0, 0, 0, 0, 2000, 0, 0, 0, 0, RES_QUIET);
        for (i = 0; i < 3; i++)
            add_row(0, 300, 65535, 0, 2000, 0, 0, 0, 0, RES_QUIET);
        for (i = 0; i < 4; i++)
            add_row(0, 0, 0, 0, 65535, 0, 0, 0, 0, RES_QUIET);
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, RES_QUIET);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        n_settings = 1;
        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (i == RECONF_ROW)
            begin
                sender_stop();
                wait_drained();
                // upper bits must be dropped by the 7-bit delay registers
                cfg_write(REG_PLUGIN_DELAY, 16'hFF81);
                cfg_write(REG_PLUGOUT_DELAY, 16'hFE01);
                cfg_stop();
                n_settings++;
            end
            send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            sender_stop();
            wait_drained();
            case (ph)
                0, 7:
                begin
                    phase_cfg[REG_SMALL_CHARGE_CURRENT] = SmallChgReset;
                    phase_cfg[REG_OUT_CHARGE_CURRENT] = OutChgReset;
                    phase_cfg[REG_UNLOAD_DISCHARGE_CURRENT] = UnloadDisReset;
                    phase_cfg[REG_VOLTAGE_OFFSET] = VoltOffsetReset;
                    phase_cfg[REG_VALID_HIGH_VOLTAGE] = HighVoltReset;
                    phase_cfg[REG_PLUGIN_DELAY] = (ph == 0) ? PluginReset : 16'd1;
                    phase_cfg[REG_PLUGOUT_DELAY] = (ph == 0) ? PlugoutReset : 16'd0;
                end
                1:
                begin
                    phase_cfg[REG_SMALL_CHARGE_CURRENT] = 16'd300;
                    phase_cfg[REG_OUT_CHARGE_CURRENT] = 16'd100;
                    phase_cfg[REG_UNLOAD_DISCHARGE_CURRENT] = 16'd500;
                    phase_cfg[REG_VOLTAGE_OFFSET] = 16'd800;
                    phase_cfg[REG_VALID_HIGH_VOLTAGE] = 16'd50000;
                    phase_cfg[REG_PLUGIN_DELAY] = 16'd2;
                    phase_cfg[REG_PLUGOUT_DELAY] = 16'd3;
                end
                2:
                    foreach (phase_cfg[k])
                        phase_cfg[k] = '0;
                LONG_PHASE:
                    foreach (phase_cfg[k])
                        phase_cfg[k] = 16'hFFFF;
                default:
                begin
                    phase_cfg[REG_SMALL_CHARGE_CURRENT] = 16'($urandom_range(0, 2000));
                    phase_cfg[REG_OUT_CHARGE_CURRENT] = 16'($urandom_range(0, 500));
                    phase_cfg[REG_UNLOAD_DISCHARGE_CURRENT] = 16'($urandom_range(0, 2000));
                    phase_cfg[REG_VOLTAGE_OFFSET] = 16'($urandom_range(0, 3000));
                    phase_cfg[REG_VALID_HIGH_VOLTAGE] = 16'($urandom_range(30000, 65535));
                    phase_cfg[REG_PLUGIN_DELAY] = 16'($urandom_range(0, 6));
                    phase_cfg[REG_PLUGOUT_DELAY] = 16'($urandom_range(0, 6));
                end
            endcase
            if (ph == 5)
                cfg_write(CFG_IDX_UNMAPPED, 16'($urandom_range(0, 65535)));
            reg_id = reg_id.first();
            repeat (reg_id.num())
            begin
                wdata = phase_cfg[reg_id];
                if (reg_id == REG_PLUGIN_DELAY || reg_id == REG_PLUGOUT_DELAY)
                    wdata[CfgDataW-1:DelayW] = 9'($urandom_range(0, 511));
                cfg_write(reg_id, wdata);
                reg_id = reg_id.next();
            end
            cfg_stop();
            n_settings++;

            if (ph < 3)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 71;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random((ph == LONG_PHASE) ? LONG_ITEMS : SHORT_ITEMS, ph == HOLD_PHASE);
        end

        sender_stop();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (status_due_q.size() != 0)
            report_mismatch("ticks left without a result", status_due_q.size(), 0);

        $display("%0d ticks under %0d register settings (%0d writes), %0d results checked",
                 n_ticks, n_settings, n_cfg, n_results);
        $display("plug-ins %0d, removals %0d, charger errors %0d, fault clears %0d, wakes %0d",
                 n_plugins, n_removals, n_err_pulses, n_clr_pulses, n_wake_pulses);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
